// File: hdl/msqd_pkg.sv
// Package for the multi-server queue dispatcher: sizes, codes and
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package msqd_pkg;
   localparam int SERVERS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF = 32;

   localparam int OP_W = 2;
   localparam int DRAW_W = 15;
   localparam int STATUS_W = 3;
   localparam int SIDX_W = 3;
   localparam int FINISH_W = 32;
   localparam int DONE_W = 4;
   localparam int NOW_W = 32;
   localparam int CNT_W = 32;
   localparam int STAY_W = 48;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_TICK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PLACED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STARTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SERVERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture item, clear scan state
      logic scan;      // visit current server
      logic advance;   // step scan index
      logic tick;      // bump the clock
      logic div_start; // launch duration remainder
      logic commit;    // apply the chosen action
      logic rd_head;   // fetch queue head entry
   } msqd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
      logic div_done;
   } msqd_sts_type;
endpackage

// File: hdl/msqd_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type set by parameter.
`timescale 1ns / 1ps
interface msqd_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/multi_server_queue_dispatcher.sv
// channel | dir | payload
// req     | in  | op, service_draw
// rsp     | out | status, server_index, finish_time, completed_now, now_time,
//         |     | served_total, stay_sum, rejected_total
// csr     | in  | csr_write_en, csr_index, csr_write_data
// One item at a time: a tick scans all SERVERS servers, an arrival or start
// scans servers_in_use; a start then runs the bit-serial duration remainder.
// Synchronous active-high reset; no clearing pass. The response holds while
// rsp ready is low and no new request is taken until it is taken.
`timescale 1ns / 1ps
module multi_server_queue_dispatcher #(
   parameter int SERVERS = msqd_pkg::SERVERS_DEF,
   parameter int QUEUE_DEPTH = msqd_pkg::QUEUE_DEPTH_DEF,
   parameter int TIME_BITS = msqd_pkg::TIME_BITS_DEF
) (
   input logic clock,
   input logic reset,
   msqd_if.sink req,
   msqd_if.source rsp,
   input logic csr_write_en,
   input logic [msqd_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [msqd_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import msqd_pkg::*;

   msqd_cmd_type cmd;
   msqd_sts_type sts;

   msqd_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_op(req.data.op),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd, .sts
   );

   msqd_dpath #(.SERVERS(SERVERS), .QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
      .clock, .reset,
      .in_op(req.data.op), .in_draw(req.data.service_draw),
      .csr_write_en, .csr_index, .csr_write_data,
      .cmd, .sts,
      .o_status(rsp.data.status), .o_sidx(rsp.data.server_index),
      .o_finish(rsp.data.finish_time), .o_done(rsp.data.completed_now),
      .o_now(rsp.data.now_time), .o_served(rsp.data.served_total),
      .o_stay(rsp.data.stay_sum), .o_reject(rsp.data.rejected_total)
   );
endmodule

// File: hdl/msqd_ctrl.sv
// Controller for the dispatcher: sequences scan, divide and commit.
// Depends on msqd_pkg.
`timescale 1ns / 1ps
module msqd_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [msqd_pkg::OP_W-1:0] in_op,
   output logic out_valid,
   input  logic out_ready,
   output msqd_pkg::msqd_cmd_type cmd,
   input  msqd_pkg::msqd_sts_type sts
);
   import msqd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_HEAD, S_COMMIT, S_OUT} state_type;
   state_type state_ff;
   logic [OP_W-1:0] op_ff;

   always_comb begin
      cmd = '0;
      cmd.load = (state_ff == S_IDLE) && in_valid && (in_op != OP_NONE);
      cmd.tick = cmd.load && (in_op == OP_TICK);
      cmd.scan = (state_ff == S_SCAN);
      cmd.advance = (state_ff == S_SCAN) && !sts.scan_last;
      cmd.div_start = (state_ff == S_SCAN) && sts.scan_last;
      cmd.rd_head = (state_ff == S_HEAD);
      cmd.commit = (state_ff == S_COMMIT);
   end

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_TICK;
      end else begin
         unique case (state_ff)
            S_IDLE: if (cmd.load) begin
               op_ff <= in_op;
               state_ff <= S_SCAN;
            end
            S_SCAN: if (sts.scan_last) begin
               state_ff <= (op_ff == OP_START) ? S_DIV : S_COMMIT;
            end
            S_DIV: if (sts.div_done) state_ff <= S_HEAD;
            S_HEAD: state_ff <= S_COMMIT;
            S_COMMIT: state_ff <= S_OUT;
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: hdl/msqd_dpath.sv
// Datapath for the dispatcher: server state, queue memory, serial
// remainder unit and statistics. Depends on msqd_pkg.
`timescale 1ns / 1ps
module msqd_dpath #(
   parameter int SERVERS = msqd_pkg::SERVERS_DEF,
   parameter int QUEUE_DEPTH = msqd_pkg::QUEUE_DEPTH_DEF,
   parameter int TIME_BITS = msqd_pkg::TIME_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [msqd_pkg::OP_W-1:0] in_op,
   input  logic [msqd_pkg::DRAW_W-1:0] in_draw,
   input  logic csr_write_en,
   input  logic [msqd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msqd_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  msqd_pkg::msqd_cmd_type cmd,
   output msqd_pkg::msqd_sts_type sts,
   output logic [msqd_pkg::STATUS_W-1:0] o_status,
   output logic [msqd_pkg::SIDX_W-1:0] o_sidx,
   output logic [msqd_pkg::FINISH_W-1:0] o_finish,
   output logic [msqd_pkg::DONE_W-1:0] o_done,
   output logic [msqd_pkg::NOW_W-1:0] o_now,
   output logic [msqd_pkg::CNT_W-1:0] o_served,
   output logic [msqd_pkg::STAY_W-1:0] o_stay,
   output logic [msqd_pkg::CNT_W-1:0] o_reject
);
   import msqd_pkg::*;

   localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MW = $clog2(SERVERS * QUEUE_DEPTH);
   localparam int MD = SERVERS * QUEUE_DEPTH;
   localparam int DW = 16;

   // config
   logic [3:0] servers_ff;
   logic [4:0] limit_ff;
   logic [15:0] min_ff, max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         servers_ff <= 4'd8;
         limit_ff <= 5'd16;
         min_ff <= 16'd1;
         max_ff <= 16'd10;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SERVERS: servers_ff <= csr_write_data[3:0];
            CSR_LIMIT: limit_ff <= csr_write_data[4:0];
            CSR_MIN: min_ff <= csr_write_data;
            CSR_MAX: max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [5:0] n_act;
   always_comb begin
      if (servers_ff == 4'd0) n_act = 6'd1;
      else if (32'(servers_ff) > SERVERS) n_act = 6'(SERVERS);
      else n_act = 6'(servers_ff);
   end
   logic [CW-1:0] lim;
   assign lim = (32'(limit_ff) < QUEUE_DEPTH) ? CW'(limit_ff) : CW'(QUEUE_DEPTH);

   // per-server state
   logic [SERVERS-1:0] busy_ff;
   logic [TIME_BITS-1:0] done_at_ff [SERVERS];
   logic [TIME_BITS-1:0] arr_ff [SERVERS];
   logic [QW-1:0] head_ff [SERVERS];
   logic [CW-1:0] count_ff [SERVERS];
   logic [TIME_BITS-1:0] now_ff;
   logic [CNT_W-1:0] served_ff, reject_ff;
   logic [STAY_W-1:0] stay_ff;

   // scan registers
   logic [SW-1:0] idx_ff;
   logic [SW-1:0] idle_ff, short_ff, start_ff;
   logic idle_found_ff, start_found_ff, all_full_ff;
   logic [DONE_W-1:0] done_ff;
   logic [CNT_W-1:0] sv_acc_ff;
   logic [STAY_W-1:0] st_acc_ff;
   logic [OP_W-1:0] op_ff;
   logic [DRAW_W-1:0] draw_ff;

   logic in_range;
   logic last_all;
   assign in_range = ({1'b0, 5'(idx_ff)} < n_act) || (op_ff == OP_TICK);
   assign last_all = (op_ff == OP_TICK) ? (32'(idx_ff) == SERVERS - 1)
                   : (6'(idx_ff) + 6'd1 >= n_act);
   assign sts.scan_last = last_all;

   logic [TIME_BITS-1:0] stay_i;
   logic [STAY_W:0] stay_sum_i;
   assign stay_i = now_ff - arr_ff[idx_ff];
   assign stay_sum_i = {1'b0, st_acc_ff} + (STAY_W+1)'(stay_i);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op;
         draw_ff <= in_draw;
         idx_ff <= '0;
         idle_found_ff <= 1'b0;
         start_found_ff <= 1'b0;
         all_full_ff <= 1'b1;
         short_ff <= '0;
         idle_ff <= '0;
         start_ff <= '0;
         done_ff <= '0;
         sv_acc_ff <= served_ff;
         st_acc_ff <= stay_ff;
      end else if (cmd.scan) begin
         if (cmd.advance) idx_ff <= idx_ff + SW'(1);
         if (op_ff == OP_TICK) begin
            if (busy_ff[idx_ff] && done_at_ff[idx_ff] == now_ff) begin
               done_ff <= done_ff + DONE_W'(1);
               if (sv_acc_ff != '1) sv_acc_ff <= sv_acc_ff + CNT_W'(1);
               st_acc_ff <= stay_sum_i[STAY_W] ? '1 : stay_sum_i[STAY_W-1:0];
            end
         end else if (in_range) begin
            if (!idle_found_ff && !busy_ff[idx_ff]) begin
               idle_found_ff <= 1'b1;
               idle_ff <= idx_ff;
            end
            if (count_ff[idx_ff] < count_ff[short_ff]) short_ff <= idx_ff;
            if (count_ff[idx_ff] < lim) all_full_ff <= 1'b0;
            if (!start_found_ff && !busy_ff[idx_ff] && count_ff[idx_ff] != '0) begin
               start_found_ff <= 1'b1;
               start_ff <= idx_ff;
            end
         end
      end
   end

   // serial restoring remainder: draw mod (max-min+1)
   logic [DW:0] divisor_ff;
   logic [DW:0] rem_ff;
   logic [DRAW_W-1:0] quo_ff;
   logic [4:0] dcnt_ff;
   logic div_busy_ff;
   logic [DW:0] rem_sh;
   assign rem_sh = {rem_ff[DW-1:0], quo_ff[DRAW_W-1]};
   assign sts.div_done = div_busy_ff && (dcnt_ff == 5'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         divisor_ff <= {1'b0, max_ff} - {1'b0, min_ff} + 17'd1;
         rem_ff <= '0;
         quo_ff <= draw_ff;
         dcnt_ff <= 5'(DRAW_W);
      end else if (div_busy_ff) begin
         if (dcnt_ff == 5'd0) begin
            div_busy_ff <= 1'b0;
         end else begin
            rem_ff <= (rem_sh >= divisor_ff) ? rem_sh - divisor_ff : rem_sh;
            quo_ff <= {quo_ff[DRAW_W-2:0], 1'b0};
            dcnt_ff <= dcnt_ff - 5'd1;
         end
      end
   end

   // waiting-time memory
   logic [TIME_BITS-1:0] mem [MD];
   logic [TIME_BITS-1:0] rd_ff;
   logic [MW-1:0] rd_addr, wr_addr;
   logic [QW-1:0] tail;
   logic [QW:0] tail_sum;
   logic [QW-1:0] head_next;
   logic do_push, is_idle_pick;
   logic [SW-1:0] push_s;
   assign is_idle_pick = idle_found_ff && count_ff[idle_ff] == '0;
   assign push_s = is_idle_pick ? idle_ff : short_ff;
   assign do_push = cmd.commit && op_ff == OP_ARRIVE && (is_idle_pick || !all_full_ff);
   // head + count stays below twice the depth: one subtract wraps it
   assign tail_sum = (QW+1)'(head_ff[push_s]) + (QW+1)'(count_ff[push_s]);
   assign tail = (32'(tail_sum) >= QUEUE_DEPTH) ? QW'(32'(tail_sum) - QUEUE_DEPTH)
               : QW'(tail_sum);
   assign head_next = (32'(head_ff[start_ff]) + 1 >= QUEUE_DEPTH) ? '0
                    : head_ff[start_ff] + QW'(1);
   assign wr_addr = MW'(32'(push_s) * QUEUE_DEPTH + 32'(tail));
   assign rd_addr = MW'(32'(start_ff) * QUEUE_DEPTH + 32'(head_ff[start_ff]));

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_addr] <= now_ff;
      if (cmd.rd_head) rd_ff <= mem[rd_addr];
   end

   logic [15:0] dur;
   assign dur = (max_ff >= min_ff) ? min_ff + rem_ff[15:0] : min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         now_ff <= '0;
         served_ff <= '0;
         reject_ff <= '0;
         stay_ff <= '0;
         for (int i = 0; i < SERVERS; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
            done_at_ff[i] <= '0;
            arr_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick) now_ff <= now_ff + TIME_BITS'(1);
         if (cmd.scan && op_ff == OP_TICK && busy_ff[idx_ff]
             && done_at_ff[idx_ff] == now_ff) busy_ff[idx_ff] <= 1'b0;
         if (cmd.commit) begin
            o_status <= ST_TICK;
            o_sidx <= '0;
            o_finish <= '0;
            o_done <= '0;
            unique case (op_ff)
               OP_TICK: begin
                  served_ff <= sv_acc_ff;
                  stay_ff <= st_acc_ff;
                  o_done <= done_ff;
               end
               OP_ARRIVE: begin
                  if (do_push) begin
                     count_ff[push_s] <= count_ff[push_s] + CW'(1);
                     o_status <= ST_PLACED;
                     o_sidx <= SIDX_W'(push_s);
                  end else begin
                     if (reject_ff != '1) reject_ff <= reject_ff + CNT_W'(1);
                     o_status <= ST_REJECT;
                  end
               end
               default: begin
                  if (start_found_ff) begin
                     arr_ff[start_ff] <= rd_ff;
                     head_ff[start_ff] <= head_next;
                     count_ff[start_ff] <= count_ff[start_ff] - CW'(1);
                     done_at_ff[start_ff] <= now_ff + TIME_BITS'(dur);
                     busy_ff[start_ff] <= 1'b1;
                     o_status <= ST_STARTED;
                     o_sidx <= SIDX_W'(start_ff);
                     o_finish <= FINISH_W'(now_ff + TIME_BITS'(dur));
                  end else begin
                     o_status <= ST_NONE;
                  end
               end
            endcase
         end
      end
   end

   assign o_now = NOW_W'(now_ff);
   assign o_served = served_ff;
   assign o_stay = stay_ff;
   assign o_reject = reject_ff;
endmodule

// File: hdl/msqd_checker.sv
// Port-level checks for the dispatcher, bound to the top level.
// Depends on msqd_pkg.
`timescale 1ns / 1ps
module msqd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [31:0] rsp_served_total
);
   import msqd_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while word pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_NONE) else $error("bad status");
   a_served: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_TICK |-> rsp_served_total == $past(rsp_served_total)
      || !$past(rsp_valid)) else $error("served changed off tick");
endmodule

bind multi_server_queue_dispatcher msqd_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status), .rsp_served_total(rsp.data.served_total)
);
